[sv/sdf_pkg.sv]
// Shared types, constants and fixed-point helpers of the smooth damp follower.
package sdf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int PROD_W    = 2 * (WORD_BITS + 1);
   localparam int MAG_W     = 2 * WORD_BITS;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic        [MAG_W-1:0]     mag_type;

   localparam word_type ONE      = word_type'(64'd1 << FRAC_BITS);
   localparam word_type TWO      = word_type'(64'd2 << FRAC_BITS);
   localparam word_type K048     = word_type'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam word_type K0235    = word_type'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam word_type FLOOR_ST = word_type'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic [1:0] CSR_SMOOTH_TIME = 2'd0;
   localparam logic [1:0] CSR_MAX_SPEED   = 2'd1;
   localparam logic [1:0] CSR_DELTA_TIME  = 2'd2;

   // magnitude plus sign back to a saturated word
   function automatic word_type from_mag(mag_type m, logic neg);
      mag_type lim;
      mag_type r;
      lim = neg ? (mag_type'(1) << (WORD_BITS-1)) : ((mag_type'(1) << (WORD_BITS-1)) - 1'b1);
      r   = (m > lim) ? lim : m;
      r   = neg ? -r : r;
      return r[WORD_BITS-1:0];
   endfunction

   function automatic word_type mulq_post(logic [PROD_W-1:0] p, logic neg);
      logic [PROD_W-1:0] s;
      s = p >> FRAC_BITS;
      return from_mag(s[MAG_W-1:0], neg);
   endfunction

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return s[WORD_BITS-1:0];
   endfunction

endpackage

[sv/sdf_ifs.sv]
// Request and response channel interfaces of the smooth damp follower.
interface sdf_req_if import sdf_pkg::*;;
   logic     valid;
   logic     ready;
   word_type current_x;
   word_type current_y;
   word_type goal_x;
   word_type goal_y;
   modport source (output valid, current_x, current_y, goal_x, goal_y, input ready);
   modport sink (input valid, current_x, current_y, goal_x, goal_y, output ready);
endinterface

interface sdf_rsp_if import sdf_pkg::*;;
   logic     valid;
   logic     ready;
   word_type next_x;
   word_type next_y;
   word_type speed_x;
   word_type speed_y;
   logic     snapped;
   modport source (output valid, next_x, next_y, speed_x, speed_y, snapped, input ready);
   modport sink (input valid, next_x, next_y, speed_x, speed_y, snapped, output ready);
endinterface

[sv/sdf_div.sv]
// Restoring fixed-point divider, one quotient bit per cycle.
module sdf_div import sdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  word_type             dvd,
   input  logic [WORD_BITS:0]   dvs,
   output logic                 done,
   output word_type             quo
);
   localparam int NUM_W = WORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]     num_ff, num_in, q_ff, q_in;
   logic [WORD_BITS:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic                 neg_ff, neg_in, zero_ff, zero_in, done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] ua;
   logic [WORD_BITS+1:0] trial, diff;
   logic                 ge;

   always_comb begin
      ua      = dvd[WORD_BITS-1] ? WORD_BITS'(-dvd) : WORD_BITS'(dvd);
      trial   = {rem_ff, num_ff[NUM_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = {ua, {FRAC_BITS{1'b0}}};
         q_in    = '0;
         rem_in  = '0;
         dvs_in  = dvs;
         neg_in  = dvd[WORD_BITS-1];
         zero_in = (ua == '0);
         cnt_in  = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = ge ? diff[WORD_BITS:0] : trial[WORD_BITS:0];
         q_in    = {q_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign quo  = zero_ff ? '0 : from_mag(MAG_W'(q_ff), neg_ff);

endmodule

[sv/sdf_sqrt.sv]
// Bit-serial integer square root of a double-width sum of squares.
module sdf_sqrt import sdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mag_type              rad,
   output logic                 done,
   output logic [WORD_BITS-1:0] root
);
   localparam int CNT_W = $clog2(WORD_BITS + 1);

   mag_type              rad_ff, rad_in;
   logic [WORD_BITS+1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS+3:0] trial, cand, diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, rad_ff[MAG_W-1:MAG_W-2]};
      cand    = {2'b00, root_ff, 2'b01};
      ge      = trial >= cand;
      diff    = trial - cand;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(WORD_BITS);
      end else if (cnt_ff != '0) begin
         rad_in  = {rad_ff[MAG_W-3:0], 2'b00};
         rem_in  = ge ? diff[WORD_BITS+1:0] : trial[WORD_BITS+1:0];
         root_in = {root_ff[WORD_BITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[sv/smooth_damp_follower_2d.sv]
// Top level of the 2D critically damped smooth damp follower.
// One transaction on req_ch (current and goal position, signed Q16.16) yields one
// transaction on rsp_ch with the next position, the updated velocity and a snap flag.
// The block holds one item at a time: req_ch.ready is high only while the sequencer is
// idle. An item takes longer when the offset has to be clamped to max_speed*smooth_time.
// Its time is set by the shared divider, which produces one quotient bit per cycle
// (two divisions always, two more on a clamp), and by the square root, one root bit
// per cycle. All multiplications go one after another through a single 33x33 multiplier
// with a registered product. A finished result sits in the output register, so the next
// item is taken while it waits; csr_* writes are expected only while the block is idle.
module smooth_damp_follower_2d import sdf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sdf_req_if.sink                req_ch,
   sdf_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [WORD_BITS-2:0]   csr_wdata
);
   // sequencer states
   localparam logic [5:0] S_IDLE   = 6'd0;
   localparam logic [5:0] S_OMEGA  = 6'd1;
   localparam logic [5:0] S_X_I    = 6'd2;
   localparam logic [5:0] S_X_C    = 6'd3;
   localparam logic [5:0] S_X2_I   = 6'd4;
   localparam logic [5:0] S_X2_C   = 6'd5;
   localparam logic [5:0] S_X3_I   = 6'd6;
   localparam logic [5:0] S_K1     = 6'd7;
   localparam logic [5:0] S_K2     = 6'd8;
   localparam logic [5:0] S_K3     = 6'd9;
   localparam logic [5:0] S_KDIV_S = 6'd10;
   localparam logic [5:0] S_KDIV_W = 6'd11;
   localparam logic [5:0] S_MC_I   = 6'd12;
   localparam logic [5:0] S_SQX    = 6'd13;
   localparam logic [5:0] S_SQY    = 6'd14;
   localparam logic [5:0] S_MQ     = 6'd15;
   localparam logic [5:0] S_CMP    = 6'd16;
   localparam logic [5:0] S_SQRT_W = 6'd17;
   localparam logic [5:0] S_DVX_S  = 6'd18;
   localparam logic [5:0] S_DVX_W  = 6'd19;
   localparam logic [5:0] S_MDX_I  = 6'd20;
   localparam logic [5:0] S_MDX_C  = 6'd21;
   localparam logic [5:0] S_DVY_S  = 6'd22;
   localparam logic [5:0] S_DVY_W  = 6'd23;
   localparam logic [5:0] S_MDY_I  = 6'd24;
   localparam logic [5:0] S_MDY_C  = 6'd25;
   localparam logic [5:0] S_VX_I   = 6'd26;
   localparam logic [5:0] S_VX_A   = 6'd27;
   localparam logic [5:0] S_VY_A   = 6'd28;
   localparam logic [5:0] S_UX     = 6'd29;
   localparam logic [5:0] S_UY     = 6'd30;
   localparam logic [5:0] S_WX     = 6'd31;
   localparam logic [5:0] S_WY     = 6'd32;
   localparam logic [5:0] S_VXN    = 6'd33;
   localparam logic [5:0] S_VYN    = 6'd34;
   localparam logic [5:0] S_OX     = 6'd35;
   localparam logic [5:0] S_OY     = 6'd36;
   localparam logic [5:0] S_DOT1   = 6'd37;
   localparam logic [5:0] S_DOT2   = 6'd38;
   localparam logic [5:0] S_DOT3   = 6'd39;
   localparam logic [5:0] S_FIN    = 6'd40;

   localparam int ACC_W = PROD_W + 2;

   logic [5:0] state_ff, state_in;

   // configuration
   logic [WORD_BITS-2:0] smooth_time_ff, smooth_time_in;
   logic [WORD_BITS-2:0] max_speed_ff, max_speed_in;
   logic [WORD_BITS-2:0] delta_time_ff, delta_time_in;
   word_type st_eff, ms_w, dt_w;

   // item and working registers
   word_type cx_ff, cx_in, cy_ff, cy_in, gx_ff, gx_in, gy_ff, gy_in;
   word_type omega_ff, omega_in, x_ff, x_in, x2_ff, x2_in, x3_ff, x3_in;
   word_type den_ff, den_in, k_ff, k_in, dx_ff, dx_in, dy_ff, dy_in;
   word_type maxc_ff, maxc_in, ta_ff, ta_in, tb_ff, tb_in;
   word_type ux_ff, ux_in, uy_ff, uy_in, ox_ff, ox_in, oy_ff, oy_in;
   word_type vx_ff, vx_in, vy_ff, vy_in;
   mag_type  sq_ff, sq_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, term;

   // shared multiplier
   logic signed [WORD_BITS:0] mul_a, mul_b;
   logic [WORD_BITS:0]        mag_a, mag_b;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      pneg_ff, pneg_in;
   word_type                  post;

   // divider and square root
   logic                      div_start, div_done, sqrt_start, sqrt_done;
   word_type                  div_a, div_q;
   logic [WORD_BITS:0]        div_b;
   logic [WORD_BITS-1:0]      root;

   // response register
   logic     rsp_valid_ff, rsp_valid_in, snap_ff, snap_in, snap;
   word_type nx_ff, nx_in, ny_ff, ny_in, sx_ff, sx_in, sy_ff, sy_in;

   logic req_take;

   function automatic logic signed [WORD_BITS:0] ext(word_type w);
      return {w[WORD_BITS-1], w};
   endfunction

   function automatic logic signed [WORD_BITS:0] diff33(word_type a, word_type b);
      return ext(a) - ext(b);
   endfunction

   sdf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvd   (div_a),
      .dvs   (div_b),
      .done  (div_done),
      .quo   (div_q)
   );

   sdf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (sq_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   assign st_eff = ({1'b0, smooth_time_ff} < FLOOR_ST) ? FLOOR_ST : {1'b0, smooth_time_ff};
   assign ms_w   = {1'b0, max_speed_ff};
   assign dt_w   = {1'b0, delta_time_ff};
   assign post   = mulq_post(prod_ff, pneg_ff);
   assign term   = pneg_ff ? -$signed({2'b00, prod_ff}) : $signed({2'b00, prod_ff});
   assign snap   = acc_ff > 0;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && (state_ff == S_IDLE);

   // configuration writes; an unknown index is ignored
   always_comb begin
      smooth_time_in = smooth_time_ff;
      max_speed_in   = max_speed_ff;
      delta_time_in  = delta_time_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SMOOTH_TIME: smooth_time_in = csr_wdata;
            CSR_MAX_SPEED:   max_speed_in   = csr_wdata;
            CSR_DELTA_TIME:  delta_time_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_X_I:   begin mul_a = ext(omega_ff); mul_b = ext(dt_w);     end
         S_X2_I:  begin mul_a = ext(x_ff);     mul_b = ext(x_ff);     end
         S_X3_I:  begin mul_a = ext(x2_ff);    mul_b = ext(x_ff);     end
         S_K1:    begin mul_a = ext(K048);     mul_b = ext(x2_ff);    end
         S_K2:    begin mul_a = ext(K0235);    mul_b = ext(x3_ff);    end
         S_MC_I:  begin mul_a = ext(ms_w);     mul_b = ext(st_eff);   end
         S_SQX:   begin mul_a = ext(dx_ff);    mul_b = ext(dx_ff);    end
         S_SQY:   begin mul_a = ext(dy_ff);    mul_b = ext(dy_ff);    end
         S_MQ:    begin mul_a = ext(maxc_in);  mul_b = ext(maxc_ff);  end
         S_MDX_I, S_MDY_I: begin mul_a = ext(ta_ff); mul_b = ext(maxc_ff); end
         S_VX_I:  begin mul_a = ext(dx_ff);    mul_b = ext(omega_ff); end
         S_VX_A:  begin mul_a = ext(dy_ff);    mul_b = ext(omega_ff); end
         S_VY_A:  begin mul_a = ext(ta_ff);    mul_b = ext(dt_w);     end
         S_UX:    begin mul_a = ext(tb_ff);    mul_b = ext(dt_w);     end
         S_UY:    begin mul_a = ext(ux_in);    mul_b = ext(omega_ff); end
         S_WX:    begin mul_a = ext(uy_ff);    mul_b = ext(omega_ff); end
         S_WY:    begin mul_a = ext(ta_ff);    mul_b = ext(k_ff);     end
         S_VXN:   begin mul_a = ext(tb_ff);    mul_b = ext(k_ff);     end
         S_VYN:   begin mul_a = ext(ta_ff);    mul_b = ext(k_ff);     end
         S_OX:    begin mul_a = ext(tb_ff);    mul_b = ext(k_ff);     end
         S_DOT1:  begin mul_a = diff33(gx_ff, cx_ff); mul_b = diff33(ox_ff, gx_ff); end
         S_DOT2:  begin mul_a = diff33(gy_ff, cy_ff); mul_b = diff33(oy_ff, gy_ff); end
         default: ;
      endcase
      mag_a   = mul_a[WORD_BITS] ? -mul_a : mul_a;
      mag_b   = mul_b[WORD_BITS] ? -mul_b : mul_b;
      prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
      pneg_in = mul_a[WORD_BITS] ^ mul_b[WORD_BITS];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; gx_in = gx_ff; gy_in = gy_ff;
      omega_in = omega_ff; x_in = x_ff; x2_in = x2_ff; x3_in = x3_ff;
      den_in = den_ff; k_in = k_ff; dx_in = dx_ff; dy_in = dy_ff;
      maxc_in = maxc_ff; ta_in = ta_ff; tb_in = tb_ff;
      ux_in = ux_ff; uy_in = uy_ff; ox_in = ox_ff; oy_in = oy_ff;
      vx_in = vx_ff; vy_in = vy_ff; sq_in = sq_ff; acc_in = acc_ff;
      nx_in = nx_ff; ny_in = ny_ff; sx_in = sx_ff; sy_in = sy_ff; snap_in = snap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      div_start  = 1'b0;
      div_a      = ONE;
      div_b      = {1'b0, den_ff};
      sqrt_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cx_in = req_ch.current_x;
               cy_in = req_ch.current_y;
               gx_in = req_ch.goal_x;
               gy_in = req_ch.goal_y;
               dx_in = sat_sub(req_ch.current_x, req_ch.goal_x);
               dy_in = sat_sub(req_ch.current_y, req_ch.goal_y);
               div_start = 1'b1;
               div_a     = TWO;
               div_b     = {1'b0, st_eff};
               state_in  = S_OMEGA;
            end
         end
         S_OMEGA: if (div_done) begin omega_in = div_q; state_in = S_X_I; end
         S_X_I:   state_in = S_X_C;
         S_X_C:   begin x_in = post; state_in = S_X2_I; end
         S_X2_I:  state_in = S_X2_C;
         S_X2_C:  begin x2_in = post; state_in = S_X3_I; end
         S_X3_I:  state_in = S_K1;
         S_K1: begin
            x3_in    = post;
            den_in   = sat_add(ONE, x_ff);
            state_in = S_K2;
         end
         S_K2:    begin den_in = sat_add(den_ff, post); state_in = S_K3; end
         S_K3:    begin den_in = sat_add(den_ff, post); state_in = S_KDIV_S; end
         S_KDIV_S: begin div_start = 1'b1; state_in = S_KDIV_W; end
         S_KDIV_W: if (div_done) begin k_in = div_q; state_in = S_MC_I; end
         S_MC_I:  state_in = S_SQX;
         S_SQX:   begin maxc_in = post; state_in = S_SQY; end
         S_SQY:   begin sq_in = prod_ff[MAG_W-1:0]; state_in = S_MQ; end
         S_MQ:    begin sq_in = sq_ff + prod_ff[MAG_W-1:0]; state_in = S_CMP; end
         S_CMP: begin
            // clamp only when the squared offset exceeds the squared limit
            if (sq_ff > prod_ff[MAG_W-1:0]) begin
               sqrt_start = 1'b1;
               state_in   = S_SQRT_W;
            end else begin
               state_in = S_VX_I;
            end
         end
         S_SQRT_W: if (sqrt_done) state_in = S_DVX_S;
         S_DVX_S: begin
            div_start = 1'b1;
            div_a     = dx_ff;
            div_b     = {1'b0, root};
            state_in  = S_DVX_W;
         end
         S_DVX_W: if (div_done) begin ta_in = div_q; state_in = S_MDX_I; end
         S_MDX_I: state_in = S_MDX_C;
         S_MDX_C: begin dx_in = post; state_in = S_DVY_S; end
         S_DVY_S: begin
            div_start = 1'b1;
            div_a     = dy_ff;
            div_b     = {1'b0, root};
            state_in  = S_DVY_W;
         end
         S_DVY_W: if (div_done) begin ta_in = div_q; state_in = S_MDY_I; end
         S_MDY_I: state_in = S_MDY_C;
         S_MDY_C: begin dy_in = post; state_in = S_VX_I; end
         S_VX_I:  state_in = S_VX_A;
         S_VX_A:  begin ta_in = sat_add(vx_ff, post); state_in = S_VY_A; end
         S_VY_A:  begin tb_in = sat_add(vy_ff, post); state_in = S_UX; end
         S_UX:    begin ux_in = post; state_in = S_UY; end
         S_UY:    begin uy_in = post; state_in = S_WX; end
         S_WX:    begin ta_in = sat_sub(vx_ff, post); state_in = S_WY; end
         S_WY:    begin tb_in = sat_sub(vy_ff, post); state_in = S_VXN; end
         S_VXN: begin
            vx_in    = post;
            ta_in    = sat_add(dx_ff, ux_ff);
            state_in = S_VYN;
         end
         S_VYN: begin
            vy_in    = post;
            tb_in    = sat_add(dy_ff, uy_ff);
            state_in = S_OX;
         end
         S_OX: begin
            ox_in    = sat_add(sat_sub(cx_ff, dx_ff), post);
            state_in = S_OY;
         end
         S_OY: begin
            oy_in    = sat_add(sat_sub(cy_ff, dy_ff), post);
            state_in = S_DOT1;
         end
         S_DOT1:  state_in = S_DOT2;
         S_DOT2:  begin acc_in = term; state_in = S_DOT3; end
         S_DOT3:  begin acc_in = acc_ff + term; state_in = S_FIN; end
         S_FIN: begin
            // overshoot guard: snap to the goal when the step passes it
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               snap_in      = snap;
               nx_in        = snap ? gx_ff : ox_ff;
               ny_in        = snap ? gy_ff : oy_ff;
               sx_in        = snap ? '0 : vx_ff;
               sy_in        = snap ? '0 : vy_ff;
               if (snap) begin
                  vx_in = '0;
                  vy_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         smooth_time_ff <= 31'd65536;
         max_speed_ff   <= 31'h7FFF_FFFF;
         delta_time_ff  <= 31'd1092;
         vx_ff          <= '0;
         vy_ff          <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         smooth_time_ff <= smooth_time_in;
         max_speed_ff   <= max_speed_in;
         delta_time_ff  <= delta_time_in;
         vx_ff          <= vx_in;
         vy_ff          <= vy_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; gx_ff <= gx_in; gy_ff <= gy_in;
      omega_ff <= omega_in; x_ff <= x_in; x2_ff <= x2_in; x3_ff <= x3_in;
      den_ff <= den_in; k_ff <= k_in; dx_ff <= dx_in; dy_ff <= dy_in;
      maxc_ff <= maxc_in; ta_ff <= ta_in; tb_ff <= tb_in;
      ux_ff <= ux_in; uy_ff <= uy_in; ox_ff <= ox_in; oy_ff <= oy_in;
      sq_ff <= sq_in; acc_ff <= acc_in;
      prod_ff <= prod_in; pneg_ff <= pneg_in;
      nx_ff <= nx_in; ny_ff <= ny_in; sx_ff <= sx_in; sy_ff <= sy_in;
      snap_ff <= snap_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.next_x  = nx_ff;
   assign rsp_ch.next_y  = ny_ff;
   assign rsp_ch.speed_x = sx_ff;
   assign rsp_ch.speed_y = sy_ff;
   assign rsp_ch.snapped = snap_ff;

endmodule
